/* src/fbm_pkg.sv */
// fbm_pkg: shared types and constants of the page frame bitmap allocator.
// Request, response and word-scan result structs, status and register codes.
// No dependencies.
`default_nettype none

package fbm_pkg;

    localparam int MAX_FRAMES_DEF = 65536;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int WORD_BITS      = 64;
    localparam int COUNT_W        = 17;
    localparam int ADDR_W         = 64;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    typedef enum logic [1:0] {
        STAT_OK            = 2'd0,
        STAT_BAD_PARAM     = 2'd1,
        STAT_NO_MEMORY     = 2'd2,
        STAT_NOT_ALLOCATED = 2'd3
    } status_t;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] CFG_TOTAL_FRAMES    = 2'd0;
    localparam logic [1:0] CFG_RESERVED_FRAMES = 2'd1;
    localparam logic [1:0] CFG_VIRTUAL_OFFSET  = 2'd2;

    typedef struct packed {
        logic   action;
        logic   physical;
        count_t page_count;
        addr_t  base_address;
    } req_t;

    typedef struct packed {
        status_t status;
        addr_t   result_address;
    } rsp_t;

    // outcome of searching one map word
    typedef struct packed {
        logic       found;
        logic       from_carry;
        logic [5:0] hit_bit;
        logic       all_free;
        logic [5:0] tail_bit;
        count_t     run_next;
    } scan_t;

endpackage

`default_nettype wire

/* src/fbm_map_ram.sv */
// fbm_map_ram: frame map storage, one write and one read port per cycle.
// Read data registered. No dependencies.
`default_nettype none

module fbm_map_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [63:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [63:0]        rd_data
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/fbm_word_scan.sv */
// fbm_word_scan: first-fit search of one 64-frame map word, with the free run
// carried in from lower words. Depends on fbm_pkg.
`default_nettype none

module fbm_word_scan (
    input  wire logic [63:0]    used,
    input  wire fbm_pkg::count_t page_count,
    input  wire fbm_pkg::count_t run_in,
    output fbm_pkg::scan_t      res
);

    import fbm_pkg::*;

    logic [63:0]      free_w;
    logic [6:0][63:0] span;
    logic [63:0]      win;
    logic [6:0]       k;
    logic [6:0]       tone;
    logic [5:0]       hz;
    logic [5:0]       lo_win;
    count_t           needed;
    logic             a_fit;
    logic             b_fit;

    assign free_w = ~used;
    assign k      = page_count[6:0];
    assign needed = page_count - run_in;

    // span[j][p]: frames p .. p+2^j-1 all free
    always_comb
    begin
        span[0] = free_w;
        for (int j = 0; j < 6; j++)
        begin
            span[j+1] = span[j] & (span[j] >> (1 << j));
        end
    end

    // win[p]: a window of k free frames starts at p
    always_comb
    begin
        win = '1;
        for (int j = 0; j < 7; j++)
        begin
            if (k[j])
            begin
                win = win & (span[j] >> (k & 7'((1 << j) - 1)));
            end
        end
    end

    always_comb
    begin
        tone   = 7'd64;
        lo_win = 6'd0;
        for (int b = 63; b >= 0; b--)
        begin
            if (!free_w[b])
            begin
                tone = 7'(b);
            end
            if (win[b])
            begin
                lo_win = 6'(b);
            end
        end
    end

    always_comb
    begin
        hz = 6'd0;
        for (int b = 0; b < 64; b++)
        begin
            if (!free_w[b])
            begin
                hz = 6'(b);
            end
        end
    end

    assign a_fit = (needed <= count_t'(WORD_BITS)) && (count_t'(tone) >= needed);
    assign b_fit = (page_count <= count_t'(WORD_BITS)) && (win != '0);

    always_comb
    begin
        res.found      = a_fit || b_fit;
        res.from_carry = a_fit && (run_in != '0);
        res.hit_bit    = a_fit ? 6'd0 : lo_win;
        res.all_free   = &free_w;
        res.tail_bit   = hz + 6'd1;
        res.run_next   = (&free_w) ? run_in + count_t'(WORD_BITS)
                                   : count_t'(6'd63 - hz);
    end

endmodule

`default_nettype wire

/* src/page_frame_bitmap_allocator.sv */
// page_frame_bitmap_allocator: top level, request sequencer around the frame map.
// Depends on fbm_pkg, fbm_map_ram, fbm_word_scan.
// After reset the map is zeroed by a clearing pass of MAX_FRAMES/64 words during
// which no request is taken; configuration writes are taken at any time. Requests
// are handled one at a time and the rate is set by the single map read port, one
// 64-frame word per cycle. An allocate reads words from the bottom until the run
// fits (up to total_frames/64 words, at most MAX_FRAMES/64), then reads and rewrites
// the words the run covers. A free reads the range once to check it and once more
// to clear it. Errors found before any map access are answered from S_IDLE or
// S_PREP. The next request is taken while the previous response still waits.
`default_nettype none

module page_frame_bitmap_allocator #(
    parameter int MAX_FRAMES = fbm_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_SHIFT = fbm_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire fbm_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output fbm_pkg::rsp_t      rsp_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [63:0]   cfg_data
);

    import fbm_pkg::*;

    localparam int MAP_WORDS = MAX_FRAMES / WORD_BITS;
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WCW       = $clog2(MAP_WORDS + 1);
    localparam int FRW       = WCW + 6;
    localparam int XW        = (FRW > COUNT_W) ? FRW : COUNT_W;
    localparam int FIRST_W   = ADDR_W - PAGE_SHIFT;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PREP  = 7'b0001000,
        S_MARK  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_FREE  = 7'b1000000
    } state_t;

    // S_DONE kept apart to keep the pass states one-hot among themselves
    logic done_reg, done_next;

    state_t            state_reg, state_next;
    logic [WAW-1:0]    clr_ptr_reg, clr_ptr_next;
    logic              issuing_reg, issuing_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              rsp_valid_reg, rsp_valid_next;
    count_t            total_reg, reserved_reg;
    addr_t             voff_reg;

    logic [WCW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [WCW-1:0]    pend_word_reg, pend_word_next;
    logic [WCW-1:0]    wend_reg, wend_next;
    count_t            carry_reg, carry_next;
    logic [FRW-1:0]    carry_start_reg, carry_start_next;
    logic [FIRST_W-1:0] first_reg, first_next;
    logic [FRW-1:0]    range_lo_reg, range_lo_next;
    logic [FRW-1:0]    range_hi_reg, range_hi_next;
    logic              action_reg, action_next;
    logic              physical_reg, physical_next;
    count_t            count_reg, count_next;
    status_t           res_status_reg, res_status_next;
    rsp_t              rsp_data_reg, rsp_data_next;

    logic              mem_wr_en, mem_rd_en;
    logic [WAW-1:0]    mem_wr_addr, mem_rd_addr;
    logic [63:0]       mem_wr_data, mem_rd_data;

    logic [63:0]       rsv_mask, rng_mask, used_w;
    logic [XW:0]       word_lo, rsv_x, end_sum;
    logic [5:0]        lo_cut, hi_cut;
    logic [WCW-1:0]    limit_words;
    logic [FRW-1:0]    start_frame;
    addr_t             phys_addr;
    logic              out_of_range, pass_state, pass_stop, issue, last_issue;
    scan_t             scan_res;

    function automatic logic [WAW-1:0] map_addr(input logic [WCW-1:0] w);
        return (w >= WCW'(MAP_WORDS)) ? '0 : w[WAW-1:0];
    endfunction

    fbm_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WAW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    fbm_word_scan u_scan (
        .used       (used_w),
        .page_count (count_reg),
        .run_in     (carry_reg),
        .res        (scan_res)
    );

    // reserved frames of the word in the data stage
    always_comb
    begin
        word_lo = (XW+1)'({pend_word_reg, 6'd0});
        rsv_x   = (XW+1)'(reserved_reg);
        if (rsv_x >= word_lo + (XW+1)'(WORD_BITS))
        begin
            rsv_mask = '1;
        end
        else if (rsv_x <= word_lo)
        begin
            rsv_mask = '0;
        end
        else
        begin
            rsv_mask = (64'd1 << reserved_reg[5:0]) - 64'd1;
        end
    end

    assign used_w = mem_rd_data | rsv_mask;

    // frames of the current range inside the word in the data stage
    always_comb
    begin
        lo_cut   = (pend_word_reg == range_lo_reg[FRW-1:6]) ? range_lo_reg[5:0] : 6'd0;
        hi_cut   = (pend_word_reg == range_hi_reg[FRW-1:6]) ? range_hi_reg[5:0] : 6'd63;
        rng_mask = ({64{1'b1}} << lo_cut) & ({64{1'b1}} >> (6'd63 - hi_cut));
    end

    assign limit_words = ((XW+1)'(total_reg) >= (XW+1)'(MAX_FRAMES))
                         ? WCW'(MAP_WORDS) : WCW'(total_reg >> 6);
    assign phys_addr   = req_data.physical ? req_data.base_address
                                           : req_data.base_address - voff_reg;
    assign start_frame = scan_res.from_carry ? carry_start_reg
                                             : {pend_word_reg, scan_res.hit_bit};
    assign end_sum     = (XW+1)'(first_reg[FRW-1:0]) + (XW+1)'(count_reg) - (XW+1)'(1);
    assign out_of_range = (first_reg >= FIRST_W'(MAX_FRAMES))
                          || (end_sum >= (XW+1)'(MAX_FRAMES));
    assign pass_state  = (state_reg == S_SCAN) || (state_reg == S_MARK)
                         || (state_reg == S_CHECK) || (state_reg == S_FREE);
    assign last_issue  = (rd_ptr_reg == wend_reg);

    always_comb
    begin
        state_next       = state_reg;
        done_next        = done_reg;
        clr_ptr_next     = clr_ptr_reg;
        issuing_next     = issuing_reg;
        rsp_valid_next   = rsp_valid_reg;
        rd_ptr_next      = rd_ptr_reg;
        pend_word_next   = pend_word_reg;
        wend_next        = wend_reg;
        carry_next       = carry_reg;
        carry_start_next = carry_start_reg;
        first_next       = first_reg;
        range_lo_next    = range_lo_reg;
        range_hi_next    = range_hi_reg;
        action_next      = action_reg;
        physical_next    = physical_reg;
        count_next       = count_reg;
        res_status_next  = res_status_reg;
        rsp_data_next    = rsp_data_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = map_addr(pend_word_reg);
        mem_wr_data      = '0;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = map_addr(rd_ptr_reg);
        pass_stop        = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (done_reg)
        begin
            if (!rsp_valid_reg || rsp_ready)
            begin
                rsp_valid_next               = 1'b1;
                rsp_data_next.status         = res_status_reg;
                rsp_data_next.result_address = '0;
                if (action_reg == ACT_ALLOC && res_status_reg == STAT_OK)
                begin
                    rsp_data_next.result_address = (ADDR_W'(range_lo_reg) << PAGE_SHIFT)
                                                   + (physical_reg ? '0 : voff_reg);
                end
                done_next  = 1'b0;
                state_next = S_IDLE;
            end
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    mem_wr_en    = 1'b1;
                    mem_wr_addr  = clr_ptr_reg;
                    clr_ptr_next = clr_ptr_reg + 1'b1;
                    if (clr_ptr_reg == WAW'(MAP_WORDS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        action_next   = req_data.action;
                        physical_next = req_data.physical;
                        count_next    = req_data.page_count;
                        if (req_data.action == ACT_ALLOC)
                        begin
                            if (req_data.page_count == '0)
                            begin
                                res_status_next = STAT_BAD_PARAM;
                                done_next       = 1'b1;
                            end
                            else if (limit_words == '0)
                            begin
                                res_status_next = STAT_NO_MEMORY;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                rd_ptr_next      = '0;
                                wend_next        = limit_words - 1'b1;
                                issuing_next     = 1'b1;
                                carry_next       = '0;
                                carry_start_next = '0;
                                state_next       = S_SCAN;
                            end
                        end
                        else
                        begin
                            first_next = phys_addr[ADDR_W-1:PAGE_SHIFT];
                            if (req_data.page_count == '0)
                            begin
                                res_status_next = STAT_OK;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = S_PREP;
                            end
                        end
                    end
                end
                S_SCAN:
                begin
                    if (pend_reg)
                    begin
                        if (scan_res.found)
                        begin
                            first_next = FIRST_W'(start_frame);
                            state_next = S_PREP;
                            pass_stop  = 1'b1;
                        end
                        else if (pend_last_reg)
                        begin
                            res_status_next = STAT_NO_MEMORY;
                            done_next       = 1'b1;
                            pass_stop       = 1'b1;
                        end
                        else
                        begin
                            carry_next = scan_res.run_next;
                            if (!scan_res.all_free)
                            begin
                                carry_start_next = {pend_word_reg, scan_res.tail_bit};
                            end
                            else if (carry_reg == '0)
                            begin
                                carry_start_next = {pend_word_reg, 6'd0};
                            end
                        end
                    end
                end
                S_PREP:
                begin
                    if (out_of_range)
                    begin
                        res_status_next = STAT_NOT_ALLOCATED;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        range_lo_next = first_reg[FRW-1:0];
                        range_hi_next = end_sum[FRW-1:0];
                        rd_ptr_next   = first_reg[FRW-1:6];
                        wend_next     = end_sum[FRW-1:6];
                        issuing_next  = 1'b1;
                        state_next    = (action_reg == ACT_ALLOC) ? S_MARK : S_CHECK;
                    end
                end
                S_MARK:
                begin
                    if (pend_reg)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data | rng_mask;
                        if (pend_last_reg)
                        begin
                            res_status_next = STAT_OK;
                            done_next       = 1'b1;
                            pass_stop       = 1'b1;
                        end
                    end
                end
                S_CHECK:
                begin
                    if (pend_reg)
                    begin
                        if ((mem_rd_data & rng_mask) != rng_mask)
                        begin
                            res_status_next = STAT_NOT_ALLOCATED;
                            done_next       = 1'b1;
                            pass_stop       = 1'b1;
                        end
                        else if (pend_last_reg)
                        begin
                            rd_ptr_next  = range_lo_reg[FRW-1:6];
                            issuing_next = 1'b1;
                            state_next   = S_FREE;
                            pass_stop    = 1'b1;
                        end
                    end
                end
                S_FREE:
                begin
                    if (pend_reg)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data & ~rng_mask;
                        if (pend_last_reg)
                        begin
                            res_status_next = STAT_OK;
                            done_next       = 1'b1;
                            pass_stop       = 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end

        // read side of the word passes
        issue          = pass_state && !done_reg && issuing_reg && !pass_stop;
        pend_next      = issue;
        pend_last_next = issue && last_issue;
        if (issue)
        begin
            mem_rd_en      = 1'b1;
            rd_ptr_next    = rd_ptr_reg + 1'b1;
            pend_word_next = rd_ptr_reg;
            issuing_next   = !last_issue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            done_reg      <= 1'b0;
            clr_ptr_reg   <= '0;
            issuing_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            total_reg     <= count_t'(65536);
            reserved_reg  <= '0;
            voff_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            clr_ptr_reg   <= clr_ptr_next;
            issuing_reg   <= issuing_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_TOTAL_FRAMES:    total_reg    <= cfg_data[COUNT_W-1:0];
                    CFG_RESERVED_FRAMES: reserved_reg <= cfg_data[COUNT_W-1:0];
                    CFG_VIRTUAL_OFFSET:  voff_reg     <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg      <= rd_ptr_next;
        pend_word_reg   <= pend_word_next;
        wend_reg        <= wend_next;
        carry_reg       <= carry_next;
        carry_start_reg <= carry_start_next;
        first_reg       <= first_next;
        range_lo_reg    <= range_lo_next;
        range_hi_reg    <= range_hi_next;
        action_reg      <= action_next;
        physical_reg    <= physical_next;
        count_reg       <= count_next;
        res_status_reg  <= res_status_next;
        rsp_data_reg    <= rsp_data_next;
    end

    assign req_ready = (state_reg == S_IDLE) && !done_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* src/fbm_checker.sv */
// fbm_checker: port-level assertions for page_frame_bitmap_allocator, bound to it.
// Depends on fbm_pkg and the top level.
`default_nettype none

module fbm_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_ready,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_ready,
    input  wire fbm_pkg::rsp_t rsp_data
);

    import fbm_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response dropped or changed while stalled");

    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != STAT_OK |-> rsp_data.result_address == '0)
        else $error("error response carries an address");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");

    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response issued without a busy cycle before it");

endmodule

bind page_frame_bitmap_allocator fbm_checker u_fbm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/sv/page_frame_bitmap_allocator_tb.sv */
// page_frame_bitmap_allocator_tb: self-checking bench for the frame bitmap allocator.
// Keeps its own copy of the frame map and registers, and predicts every response.
// Depends on fbm_pkg and page_frame_bitmap_allocator.
`default_nettype none

module page_frame_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbm_pkg::*;

    localparam int unsigned NUM_FRAMES = MAX_FRAMES_DEF;
    localparam int unsigned MAP_WORDS  = NUM_FRAMES / WORD_BITS;
    localparam int unsigned PG_SHIFT   = PAGE_SHIFT_DEF;
    localparam logic [1:0]  CFG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_CAP  = 4_000_000;
    localparam int unsigned RAND_PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 70;

    typedef struct {
        longint unsigned base_frame;
        int unsigned     frames;
    } frame_run_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req_data = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    logic [63:0]     frame_map [MAP_WORDS];
    int unsigned     total_frames_q = 65536;
    int unsigned     reserved_frames_q = 0;
    addr_t           virt_offset_q = '0;

    req_t            pending_reqs [$];
    rsp_t            expected_rsp [$];
    frame_run_t      live_runs [$];
    rsp_t            want;
    int unsigned     errors = 0;
    int unsigned     cycles = 0;
    int              req_gap_left = 0;
    int              rsp_stall_left = 0;
    bit              gaps_on = 1'b1;
    bit              stalls_on = 1'b1;

    int unsigned phase_total [RAND_PHASES] = '{1024, 2048, 131071, 700, 4096, 65536, 1536, 512};
    int unsigned phase_resv  [RAND_PHASES] = '{0, 37, 65000, 130, 4000, 0, 64, 511};

    page_frame_bitmap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] reserve_mask(longint unsigned w);
        longint unsigned lo;
        lo = w * WORD_BITS;
        if (reserved_frames_q >= lo + WORD_BITS)
            return '1;
        if (reserved_frames_q <= lo)
            return '0;
        return (64'd1 << (reserved_frames_q - lo)) - 64'd1;
    endfunction

    // allocate or free against the shadow map, returns the expected response
    function automatic rsp_t serve_request(req_t rq);
        rsp_t            r;
        longint unsigned lim, words, runlen, start, w, b, i, f, first_frame;
        logic [63:0]     used;
        addr_t           phys;
        bit              found, ok;
        int unsigned     cnt;
        r.status = STAT_OK;
        r.result_address = '0;
        cnt = rq.page_count;
        start = 0;
        if (rq.action == ACT_ALLOC)
        begin
            lim = (total_frames_q > NUM_FRAMES) ? NUM_FRAMES : total_frames_q;
            words = lim >> 6;
            runlen = 0;
            found = 1'b0;
            if (cnt == 0)
                r.status = STAT_BAD_PARAM;
            else
            begin
                for (w = 0; w < words && !found; w++)
                begin
                    used = frame_map[w] | reserve_mask(w);
                    if (used == '1)
                        runlen = 0;
                    else
                        for (b = 0; b < WORD_BITS && !found; b++)
                        begin
                            if (used[b])
                                runlen = 0;
                            else
                            begin
                                if (runlen == 0)
                                    start = w * WORD_BITS + b;
                                runlen++;
                                if (runlen == cnt)
                                    found = 1'b1;
                            end
                        end
                end
                if (!found)
                    r.status = STAT_NO_MEMORY;
                else
                begin
                    for (i = 0; i < cnt; i++)
                        frame_map[(start + i) >> 6][(start + i) % WORD_BITS] = 1'b1;
                    r.result_address = addr_t'(start) << PG_SHIFT;
                    if (!rq.physical)
                        r.result_address = r.result_address + virt_offset_q;
                    live_runs.push_back('{start, cnt});
                end
            end
        end
        else
        begin
            phys = rq.physical ? rq.base_address : rq.base_address - virt_offset_q;
            first_frame = phys >> PG_SHIFT;
            ok = 1'b1;
            for (i = 0; i < cnt && ok; i++)
            begin
                f = first_frame + i;
                if (f >= NUM_FRAMES)
                    ok = 1'b0;
                else if (!frame_map[f >> 6][f % WORD_BITS])
                    ok = 1'b0;
            end
            if (!ok)
                r.status = STAT_NOT_ALLOCATED;
            else if (cnt != 0)
            begin
                for (i = 0; i < cnt; i++)
                    frame_map[(first_frame + i) >> 6][(first_frame + i) % WORD_BITS] = 1'b0;
                for (int k = live_runs.size() - 1; k >= 0; k--)
                    if (live_runs[k].base_frame < first_frame + cnt &&
                        first_frame < live_runs[k].base_frame + live_runs[k].frames)
                        live_runs.delete(k);
            end
        end
        return r;
    endfunction

    function automatic addr_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic addr_t frame_to_addr(longint unsigned frame, logic phys);
        addr_t a;
        a = (addr_t'(frame) << PG_SHIFT) | addr_t'($urandom_range(0, 4095));
        if (!phys)
            a = a + virt_offset_q;
        return a;
    endfunction

    function automatic void push_req(logic act, logic phys, count_t cnt, addr_t addr);
        req_t rq;
        rq.action = act;
        rq.physical = phys;
        rq.page_count = cnt;
        rq.base_address = addr;
        pending_reqs.push_back(rq);
    endfunction

    // mostly allocations and frees of live runs, some stray frees and noise
    function automatic req_t make_request();
        req_t        rq;
        frame_run_t  rec;
        int unsigned pick, lim, off, len, sz;
        rq.action = ACT_ALLOC;
        rq.physical = 1'($urandom_range(0, 1));
        rq.base_address = rand64();
        lim = (total_frames_q > NUM_FRAMES) ? NUM_FRAMES : total_frames_q;
        pick = $urandom_range(0, 99);
        if (pick >= 90)
        begin
            rq.action = 1'($urandom_range(0, 1));
            rq.page_count = $urandom_range(0, 1) ? count_t'($urandom)
                                                 : count_t'($urandom_range(0, 3));
        end
        else if (pick >= 80)
        begin
            rq.action = ACT_FREE;
            rq.page_count = count_t'($urandom_range(1, 4));
            rq.base_address = frame_to_addr($urandom_range(0, lim + 16), rq.physical);
        end
        else if (pick >= 45 && live_runs.size() != 0)
        begin
            rec = live_runs[$urandom_range(0, live_runs.size() - 1)];
            off = 0;
            len = rec.frames;
            if ($urandom_range(0, 3) == 0)
            begin
                off = $urandom_range(0, rec.frames - 1);
                len = $urandom_range(1, rec.frames - off);
            end
            rq.action = ACT_FREE;
            rq.page_count = count_t'(len);
            rq.base_address = frame_to_addr(rec.base_frame + off, rq.physical);
        end
        else
        begin
            sz = $urandom_range(0, 19);
            if (sz < 14)
                rq.page_count = count_t'($urandom_range(1, 8));
            else if (sz < 19)
                rq.page_count = count_t'($urandom_range(9, 100));
            else
                rq.page_count = count_t'($urandom_range(1, (lim > 0) ? lim : 1));
        end
        return rq;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TOTAL_FRAMES:    total_frames_q = val[COUNT_W-1:0];
            CFG_RESERVED_FRAMES: reserved_frames_q = val[COUNT_W-1:0];
            CFG_VIRTUAL_OFFSET:  virt_offset_q = val;
            default: ;
        endcase
    endtask

    task automatic settle(int unsigned tail);
        while (pending_reqs.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    // request driver, predicts each transfer as it is accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_rsp.push_back(serve_request(req_data));
            if (!req_valid || req_ready)
            begin
                if (req_gap_left > 0)
                begin
                    req_gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req_data <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 5) == 0)
                        req_gap_left = $urandom_range(1, 6);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected response: status %0d address %h",
                           rsp_data.status, rsp_data.result_address);
                    errors++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                        errors++;
                    end
                    if (rsp_data.result_address !== want.result_address)
                    begin
                        $error("result_address: expected %h, got %h",
                               want.result_address, rsp_data.result_address);
                        errors++;
                    end
                end
            end
            if (rsp_stall_left > 0)
            begin
                rsp_stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (stalls_on && $urandom_range(0, 7) == 0)
                    rsp_stall_left = $urandom_range(1, 6);
            end
        end
    end

    initial
    begin
        for (int w = 0; w < MAP_WORDS; w++)
            frame_map[w] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero counts, whole-map run, oversize counts, stray frees
        push_req(ACT_ALLOC, 1'b1, 17'd0, rand64());
        push_req(ACT_FREE, 1'b1, 17'd0, rand64());
        push_req(ACT_ALLOC, 1'b1, 17'd1, rand64());
        push_req(ACT_ALLOC, 1'b0, 17'd65536, rand64());
        push_req(ACT_FREE, 1'b1, 17'd1, 64'hFFF);
        push_req(ACT_ALLOC, 1'b1, 17'd65536, rand64());
        push_req(ACT_ALLOC, 1'b0, 17'd1, rand64());
        push_req(ACT_FREE, 1'b1, 17'd65536, 64'd0);
        push_req(ACT_ALLOC, 1'b0, 17'h1FFFF, rand64());
        push_req(ACT_FREE, 1'b1, 17'h1FFFF, 64'd0);
        push_req(ACT_FREE, 1'b1, 17'd1, '1);
        push_req(ACT_FREE, 1'b1, 17'd1, frame_to_addr(5, 1'b1));
        settle(10);

        // total above the map, reserved low frames, wrapping offset
        write_reg(CFG_TOTAL_FRAMES, '1);
        write_reg(CFG_RESERVED_FRAMES, 64'd100);
        write_reg(CFG_VIRTUAL_OFFSET, 64'hFFFF_FFFF_FFFF_F000);
        write_reg(CFG_UNUSED, rand64());
        push_req(ACT_ALLOC, 1'b0, 17'd1, rand64());
        push_req(ACT_FREE, 1'b1, 17'd1, frame_to_addr(5, 1'b1));
        push_req(ACT_FREE, 1'b0, 17'd1, frame_to_addr(100, 1'b0));
        push_req(ACT_ALLOC, 1'b1, 17'd64, rand64());
        push_req(ACT_FREE, 1'b1, 17'd64, frame_to_addr(100, 1'b1));
        settle(10);

        // no whole word searchable
        write_reg(CFG_TOTAL_FRAMES, 64'd63);
        write_reg(CFG_RESERVED_FRAMES, 64'd0);
        push_req(ACT_ALLOC, 1'b1, 17'd1, rand64());
        push_req(ACT_FREE, 1'b1, 17'd1, frame_to_addr(0, 1'b1));
        settle(10);
        write_reg(CFG_TOTAL_FRAMES, 64'd0);
        push_req(ACT_ALLOC, 1'b0, 17'd1, rand64());
        settle(10);

        // everything reserved, then one full word
        write_reg(CFG_TOTAL_FRAMES, 64'd64);
        write_reg(CFG_RESERVED_FRAMES, 64'h1FFFF);
        push_req(ACT_ALLOC, 1'b1, 17'd1, rand64());
        settle(10);
        write_reg(CFG_RESERVED_FRAMES, 64'd0);
        push_req(ACT_ALLOC, 1'b1, 17'd64, rand64());
        push_req(ACT_FREE, 1'b1, 17'd64, frame_to_addr(0, 1'b1));
        settle(10);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_reg(CFG_TOTAL_FRAMES, (p % 2) ? ((rand64() & ~64'h1FFFF) | phase_total[p])
                                                : 64'(phase_total[p]));
            write_reg(CFG_RESERVED_FRAMES, (p % 2) ? ((rand64() & ~64'h1FFFF) | phase_resv[p])
                                                   : 64'(phase_resv[p]));
            write_reg(CFG_VIRTUAL_OFFSET, (p == 0) ? 64'd0 : (p == 1) ? '1 : rand64());
            gaps_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            stalls_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                while (pending_reqs.size() >= 2)
                    @(negedge clk);
                pending_reqs.push_back(make_request());
            end
            settle((p == RAND_PHASES - 1) ? 40 : 10);
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
